FILE: rtl/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// Shared codes, constants and cell control type of the sorted timeout queue.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_CHECK  = 2'd2;

  localparam int unsigned DELAY_W = 31;
  localparam int unsigned PROD_W  = 41;
  localparam logic [9:0]  US_PER_MS = 10'd1000;
  localparam logic [47:0] DELAY_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [4:0]  REMOVED_MAX = 5'd31;

  typedef struct packed {
    logic ins;
    logic rem;
    logic pop;
    logic push;
    logic emit;
  } cell_ctrl_t;

endpackage

FILE: rtl/sorted_timeout_queue.sv
// ----------------------------------------------------------------------------
// sorted_timeout_queue
// Timeout queue kept in expiry order in a chain of cells.
// ----------------------------------------------------------------------------
// An input item carries a command, an owner, a delay in ms and the current
// time in us. Add places now + delay*1000 after all entries of equal expiry,
// remove deletes every entry of one owner, check pops every entry due at now.
// Every item gives one result, a check that pops n entries gives n results,
// each with the delay from now to the head entry left after the item.
// One item is in work at a time; in_stall_o is high while it is.
// Add runs through expiry sum, chain insert, head delay and result; the
// product is formed as the item is taken, and a full queue skips the insert.
// Remove lets the chain drop the first matching entry each cycle; check pops
// the due head entry each cycle, then gives a further result per cycle
// while out_stall_i is low. An unused command only gets head delay and result.
// The result register holds while out_stall_i is high; the next item can be
// taken while the last result of the previous one still waits there.
// Reset empties the queue at once; the cell contents need no clearing.
// ----------------------------------------------------------------------------
module sorted_timeout_queue #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned OWNER_BITS  = 8,
  parameter int unsigned TIME_BITS   = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  owner_id_i,
  input  logic [30:0] delay_ms_i,
  input  logic [47:0] now_us_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        expired_valid_o,
  output logic [7:0]  expired_owner_o,
  output logic        last_of_run_o,
  output logic        rearm_o,
  output logic        queue_empty_o,
  output logic [47:0] next_delay_us_o,
  output logic        full_error_o,
  output logic [4:0]  removed_count_o
);

  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PROD_W = stq_pkg::PROD_W;
  localparam int unsigned SUM_W  = ((TIME_BITS > PROD_W) ? TIME_BITS : PROD_W) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_REM  = 3'd3;
  localparam logic [2:0] S_POP  = 3'd4;
  localparam logic [2:0] S_DLY  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      rm_cnt_q, rm_cnt_d;
  logic [CNT_W-1:0]      pop_cnt_q, pop_cnt_d;
  logic                  full_q, full_d;
  logic                  rearm_q, rearm_d;
  logic                  live_q, live_d;

  logic [1:0]            cmd_q;
  logic [OWNER_BITS-1:0] owner_q;
  logic [TIME_BITS-1:0]  now_q;
  logic [PROD_W-1:0]     prod_q;
  logic [TIME_BITS-1:0]  exp_q;
  logic [TIME_BITS-1:0]  diff_q;

  logic [SUM_W-1:0]      sum;
  logic [TIME_BITS-1:0]  exp_sat;
  logic                  accept;
  logic                  load;
  logic                  last;
  logic                  head_due;
  logic [47:0]           delay_val;

  stq_pkg::cell_ctrl_t   ctrl;

  logic [TIME_BITS-1:0]  c_exp   [QUEUE_DEPTH];
  logic [OWNER_BITS-1:0] c_owner [QUEUE_DEPTH];
  logic [OWNER_BITS-1:0] c_pop   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] c_cmp;
  logic [QUEUE_DEPTH-1:0] c_seen;

  logic                  out_valid_q;
  logic                  o_exp_valid_q;
  logic [7:0]            o_owner_q;
  logic                  o_last_q;
  logic                  o_rearm_q;
  logic                  o_empty_q;
  logic [47:0]           o_delay_q;
  logic                  o_full_q;
  logic [4:0]            o_removed_q;

  // chain of cells
  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    logic                  l_cmp;
    logic [TIME_BITS-1:0]  l_exp;
    logic [OWNER_BITS-1:0] l_owner;
    logic [TIME_BITS-1:0]  r_exp;
    logic [OWNER_BITS-1:0] r_owner;
    logic [OWNER_BITS-1:0] r_pop;
    logic                  s_in;

    if (k == 0) begin : g_head
      assign l_cmp   = 1'b1;
      assign l_exp   = '0;
      assign l_owner = '0;
      assign s_in    = 1'b0;
    end else begin : g_body
      assign l_cmp   = c_cmp[k-1];
      assign l_exp   = c_exp[k-1];
      assign l_owner = c_owner[k-1];
      assign s_in    = c_seen[k-1];
    end

    if (k == QUEUE_DEPTH - 1) begin : g_tail
      assign r_exp   = '0;
      assign r_owner = '0;
      assign r_pop   = '0;
    end else begin : g_mid
      assign r_exp   = c_exp[k+1];
      assign r_owner = c_owner[k+1];
      assign r_pop   = c_pop[k+1];
    end

    stq_cell #(
      .TIME_BITS  (TIME_BITS),
      .OWNER_BITS (OWNER_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (CNT_W'(k) < count_q),
      .key_exp_i    (exp_q),
      .key_owner_i  (owner_q),
      .left_cmp_i   (l_cmp),
      .left_exp_i   (l_exp),
      .left_owner_i (l_owner),
      .right_exp_i  (r_exp),
      .right_owner_i(r_owner),
      .right_pop_i  (r_pop),
      .seen_i       (s_in),
      .push_sel_i   (pop_cnt_q == CNT_W'(k)),
      .push_owner_i (c_owner[0]),
      .exp_o        (c_exp[k]),
      .owner_o      (c_owner[k]),
      .pop_owner_o  (c_pop[k]),
      .cmp_o        (c_cmp[k]),
      .seen_o       (c_seen[k])
    );
  end

  assign accept   = (state_q == S_IDLE) && in_valid_i;
  assign load     = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);
  assign last     = !((cmd_q == stq_pkg::CMD_CHECK) && (pop_cnt_q > CNT_W'(1)));
  assign head_due = (count_q != '0) && (c_exp[0] <= now_q);

  assign sum     = SUM_W'(now_q) + SUM_W'(prod_q);
  assign exp_sat = (sum[SUM_W-1:TIME_BITS] != '0) ? '1 : sum[TIME_BITS-1:0];

  assign delay_val = !live_q ? 48'd0 :
                     (64'(diff_q) > 64'(stq_pkg::DELAY_MAX)) ? stq_pkg::DELAY_MAX :
                     48'(diff_q);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rm_cnt_d  = rm_cnt_q;
    pop_cnt_d = pop_cnt_q;
    full_d    = full_q;
    rearm_d   = rearm_q;
    live_d    = live_q;
    ctrl      = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          rm_cnt_d  = '0;
          pop_cnt_d = '0;
          full_d    = 1'b0;
          rearm_d   = 1'b0;
          case (command_i)
            stq_pkg::CMD_ADD:    state_d = S_SUM;
            stq_pkg::CMD_REMOVE: state_d = S_REM;
            stq_pkg::CMD_CHECK:  state_d = S_POP;
            default:             state_d = S_DLY;
          endcase
        end
      end
      S_SUM: begin
        if (count_q == CNT_W'(QUEUE_DEPTH)) begin
          full_d  = 1'b1;
          state_d = S_DLY;
        end else begin
          state_d = S_INS;
        end
      end
      S_INS: begin
        ctrl.ins = 1'b1;
        rearm_d  = !c_cmp[0];
        count_d  = count_q + CNT_W'(1);
        state_d  = S_DLY;
      end
      S_REM: begin
        if (c_seen[QUEUE_DEPTH-1]) begin
          ctrl.rem = 1'b1;
          count_d  = count_q - CNT_W'(1);
          rm_cnt_d = rm_cnt_q + CNT_W'(1);
        end else begin
          state_d = S_DLY;
        end
      end
      S_POP: begin
        if (head_due) begin
          ctrl.pop  = 1'b1;
          ctrl.push = 1'b1;
          count_d   = count_q - CNT_W'(1);
          pop_cnt_d = pop_cnt_q + CNT_W'(1);
        end else begin
          state_d = S_DLY;
        end
      end
      S_DLY: begin
        live_d = (count_q != '0) && (now_q < c_exp[0]);
        if (cmd_q == stq_pkg::CMD_CHECK) begin
          rearm_d = (count_q != '0);
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (load) begin
          if (last) begin
            state_d = S_IDLE;
          end else begin
            ctrl.emit = 1'b1;
            pop_cnt_d = pop_cnt_q - CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rm_cnt_q    <= '0;
      pop_cnt_q   <= '0;
      full_q      <= 1'b0;
      rearm_q     <= 1'b0;
      live_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rm_cnt_q  <= rm_cnt_d;
      pop_cnt_q <= pop_cnt_d;
      full_q    <= full_d;
      rearm_q   <= rearm_d;
      live_q    <= live_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= command_i;
      owner_q <= OWNER_BITS'(owner_id_i);
      now_q   <= TIME_BITS'(now_us_i);
      prod_q  <= PROD_W'(delay_ms_i) * PROD_W'(stq_pkg::US_PER_MS);
    end
    if (state_q == S_SUM) begin
      exp_q <= exp_sat;
    end
    if (state_q == S_DLY) begin
      diff_q <= c_exp[0] - now_q;
    end
    if (load) begin
      o_exp_valid_q <= (cmd_q == stq_pkg::CMD_CHECK) && (pop_cnt_q != '0);
      o_owner_q     <= ((cmd_q == stq_pkg::CMD_CHECK) && (pop_cnt_q != '0)) ?
                       8'(c_pop[0]) : 8'd0;
      o_last_q      <= last;
      o_rearm_q     <= rearm_q;
      o_empty_q     <= (count_q == '0);
      o_delay_q     <= delay_val;
      o_full_q      <= full_q;
      o_removed_q   <= (32'(rm_cnt_q) > 32'(stq_pkg::REMOVED_MAX)) ?
                       stq_pkg::REMOVED_MAX : 5'(rm_cnt_q);
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign expired_valid_o = o_exp_valid_q;
  assign expired_owner_o = o_owner_q;
  assign last_of_run_o   = o_last_q;
  assign rearm_o         = o_rearm_q;
  assign queue_empty_o   = o_empty_q;
  assign next_delay_us_o = o_delay_q;
  assign full_error_o    = o_full_q;
  assign removed_count_o = o_removed_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not grow the queue by one");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM && count_q == CNT_W'(QUEUE_DEPTH)) |=> (full_q && state_q == S_DLY))
    else $error("add on a full queue not flagged");

  a_pop_conserve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |=>
      ((CNT_W+1)'(count_q) + (CNT_W+1)'(pop_cnt_q) ==
       (CNT_W+1)'($past(count_q)) + (CNT_W+1)'($past(pop_cnt_q))))
    else $error("pop lost or duplicated an entry");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && last) |=> (state_q == S_IDLE && out_valid_q && o_last_q))
    else $error("final result did not end the item");

endmodule

FILE: rtl/stq_cell.sv
// ----------------------------------------------------------------------------
// stq_cell
// One slot of the sorted chain: holds an expiry, its owner and one popped
// owner, and moves them to or from its neighbors on insert, remove, pop and emit.
// ----------------------------------------------------------------------------
module stq_cell #(
  parameter int unsigned TIME_BITS  = 48,
  parameter int unsigned OWNER_BITS = 8
) (
  input  logic                   clk_i,
  input  stq_pkg::cell_ctrl_t    ctrl_i,
  input  logic                   occupied_i,
  input  logic [TIME_BITS-1:0]   key_exp_i,
  input  logic [OWNER_BITS-1:0]  key_owner_i,
  input  logic                   left_cmp_i,
  input  logic [TIME_BITS-1:0]   left_exp_i,
  input  logic [OWNER_BITS-1:0]  left_owner_i,
  input  logic [TIME_BITS-1:0]   right_exp_i,
  input  logic [OWNER_BITS-1:0]  right_owner_i,
  input  logic [OWNER_BITS-1:0]  right_pop_i,
  input  logic                   seen_i,
  input  logic                   push_sel_i,
  input  logic [OWNER_BITS-1:0]  push_owner_i,
  output logic [TIME_BITS-1:0]   exp_o,
  output logic [OWNER_BITS-1:0]  owner_o,
  output logic [OWNER_BITS-1:0]  pop_owner_o,
  output logic                   cmp_o,
  output logic                   seen_o
);

  logic [TIME_BITS-1:0]  exp_q, exp_d;
  logic [OWNER_BITS-1:0] owner_q, owner_d;
  logic [OWNER_BITS-1:0] pop_q, pop_d;
  logic                  match;

  assign cmp_o  = occupied_i && (exp_q <= key_exp_i);
  assign match  = occupied_i && (owner_q == key_owner_i);
  assign seen_o = seen_i | match;

  always_comb begin
    exp_d   = exp_q;
    owner_d = owner_q;
    pop_d   = pop_q;
    if (ctrl_i.ins && !cmp_o) begin
      if (left_cmp_i) begin
        exp_d   = key_exp_i;
        owner_d = key_owner_i;
      end else begin
        exp_d   = left_exp_i;
        owner_d = left_owner_i;
      end
    end
    if ((ctrl_i.rem && seen_o) || ctrl_i.pop) begin
      exp_d   = right_exp_i;
      owner_d = right_owner_i;
    end
    if (ctrl_i.push && push_sel_i) begin
      pop_d = push_owner_i;
    end
    if (ctrl_i.emit) begin
      pop_d = right_pop_i;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q   <= exp_d;
    owner_q <= owner_d;
    pop_q   <= pop_d;
  end

  assign exp_o       = exp_q;
  assign owner_o     = owner_q;
  assign pop_owner_o = pop_q;

endmodule
